/* hw/rtl/ltob_pkg.sv */
package ltob_pkg;

    localparam int SPD_FIELD_W = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_FORCE = 1'd1;

    localparam logic [2:0] CMD_SPEED = 3'd0;
    localparam logic [2:0] CMD_STOP = 3'd1;
    localparam logic [2:0] CMD_TLEFT = 3'd2;
    localparam logic [2:0] CMD_TRIGHT = 3'd3;
    localparam logic [2:0] CMD_TURN = 3'd4;
    localparam logic [2:0] CMD_FWD = 3'd5;

    localparam logic [2:0] M_READY = 3'd0;
    localparam logic [2:0] M_SEARCH = 3'd1;
    localparam logic [2:0] M_TRACE = 3'd2;
    localparam logic [2:0] M_PREP = 3'd3;
    localparam logic [2:0] M_SBACK = 3'd4;
    localparam logic [2:0] M_TBACK = 3'd5;
    localparam logic [2:0] M_DONE = 3'd6;

    localparam logic [7:0] TURN_RATE_K = 8'd120;
    localparam logic [15:0] TURN_TIME_K = 16'd1000;

    typedef struct packed {
        logic       front_left_black;
        logic       front_mid_black;
        logic       front_right_black;
        logic       back_left_black;
        logic       back_mid_black;
        logic       back_right_black;
        logic [7:0] left_wheel_speed;
        logic [7:0] right_wheel_speed;
        logic       left_wheel_dir;
        logic       right_wheel_dir;
    } in_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  speed;
        logic [7:0]  torque;
        logic        interruptible;
        logic [7:0]  turn_rate;
        logic [15:0] turn_time;
        logic [2:0]  mode;
    } out_t;

    typedef struct packed {
        logic [7:0] cruise_speed;
        logic [7:0] torque_force;
    } cfg_t;

endpackage

/* hw/rtl/ltob_cfg_regs.sv */
module ltob_cfg_regs #(
    parameter int SPEED_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [ltob_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    output ltob_pkg::cfg_t                 cfg
);

    localparam int SPD_W = (SPEED_BITS < ltob_pkg::SPD_FIELD_W) ?
                           SPEED_BITS : ltob_pkg::SPD_FIELD_W;

    logic [SPD_W-1:0] cruise_speed_reg;
    logic [7:0]       torque_force_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_speed_reg <= '0;
            torque_force_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ltob_pkg::CFG_CRUISE_SPEED: cruise_speed_reg <= cfg_data[SPD_W-1:0];
                ltob_pkg::CFG_TORQUE_FORCE: torque_force_reg <= cfg_data;
                default:                    torque_force_reg <= torque_force_reg;
            endcase
        end
    end

    // cruise speed is kept only to the speed width, zero-extended on the way out
    assign cfg.cruise_speed = 8'(cruise_speed_reg);
    assign cfg.torque_force = torque_force_reg;

endmodule

/* hw/rtl/ltob_decide.sv */
module ltob_decide #(
    parameter int SPEED_BITS = 8
) (
    input  logic [2:0]     mode,
    input  ltob_pkg::in_t  req,
    input  ltob_pkg::cfg_t cfg,
    output ltob_pkg::out_t res
);

    localparam int SPD_W = (SPEED_BITS < ltob_pkg::SPD_FIELD_W) ?
                           SPEED_BITS : ltob_pkg::SPD_FIELD_W;
    localparam logic [7:0] SPD_MASK = 8'((17'(1) << SPD_W) - 17'(1));

    logic       any_front;
    logic       all_white;
    logic       stalled;
    logic       dir_differ;
    logic [2:0] steer_cmd;
    logic       steer_intr;
    logic [2:0] cmd;
    logic       intr;
    logic [2:0] mode_next;
    logic       is_torque;

    assign any_front  = req.front_left_black | req.front_mid_black | req.front_right_black;
    assign all_white  = !(any_front | req.back_left_black | req.back_mid_black |
                          req.back_right_black);
    assign stalled    = ((req.left_wheel_speed & SPD_MASK) == 8'd0) ||
                        ((req.right_wheel_speed & SPD_MASK) == 8'd0);
    assign dir_differ = req.left_wheel_dir != req.right_wheel_dir;

    // steering priority: front left, front right, front mid, back left, back right
    always_comb
    begin
        steer_cmd  = ltob_pkg::CMD_SPEED;
        steer_intr = 1'b0;
        if (req.front_left_black)
        begin
            steer_cmd  = ltob_pkg::CMD_TLEFT;
            steer_intr = 1'b1;
        end
        else if (req.front_right_black)
        begin
            steer_cmd  = ltob_pkg::CMD_TRIGHT;
            steer_intr = 1'b1;
        end
        else if (req.front_mid_black)
        begin
            steer_cmd  = ltob_pkg::CMD_SPEED;
        end
        else if (req.back_left_black)
        begin
            steer_cmd  = ltob_pkg::CMD_TLEFT;
            steer_intr = 1'b1;
        end
        else if (req.back_right_black)
        begin
            steer_cmd  = ltob_pkg::CMD_TRIGHT;
            steer_intr = 1'b1;
        end
    end

    always_comb
    begin
        cmd       = ltob_pkg::CMD_STOP;
        intr      = 1'b0;
        mode_next = mode;
        unique case (mode)
            ltob_pkg::M_READY:
            begin
                cmd       = ltob_pkg::CMD_SPEED;
                mode_next = ltob_pkg::M_SEARCH;
            end
            ltob_pkg::M_SEARCH:
            begin
                if (any_front)
                begin
                    cmd       = ltob_pkg::CMD_STOP;
                    mode_next = ltob_pkg::M_TRACE;
                end
                else
                begin
                    cmd = ltob_pkg::CMD_SPEED;
                end
            end
            ltob_pkg::M_TRACE:
            begin
                if (stalled)
                begin
                    cmd = ltob_pkg::CMD_SPEED;
                end
                else if (all_white)
                begin
                    cmd       = ltob_pkg::CMD_STOP;
                    intr      = 1'b1;
                    mode_next = ltob_pkg::M_PREP;
                end
                else
                begin
                    cmd  = steer_cmd;
                    intr = steer_intr;
                end
            end
            ltob_pkg::M_PREP:
            begin
                cmd       = ltob_pkg::CMD_TURN;
                mode_next = ltob_pkg::M_SBACK;
            end
            ltob_pkg::M_SBACK:
            begin
                if (any_front)
                begin
                    cmd       = ltob_pkg::CMD_STOP;
                    intr      = 1'b1;
                    mode_next = ltob_pkg::M_TBACK;
                end
                else
                begin
                    cmd = ltob_pkg::CMD_SPEED;
                end
            end
            ltob_pkg::M_TBACK:
            begin
                if (dir_differ)
                begin
                    cmd = ltob_pkg::CMD_FWD;
                end
                else if (stalled)
                begin
                    cmd = ltob_pkg::CMD_SPEED;
                end
                else if (all_white)
                begin
                    cmd       = ltob_pkg::CMD_STOP;
                    mode_next = ltob_pkg::M_DONE;
                end
                else
                begin
                    cmd  = steer_cmd;
                    intr = steer_intr;
                end
            end
            default:
            begin
                // finished, and the unused code falls in here too
                cmd       = ltob_pkg::CMD_STOP;
                mode_next = ltob_pkg::M_DONE;
            end
        endcase
    end

    assign is_torque = (cmd == ltob_pkg::CMD_TLEFT) || (cmd == ltob_pkg::CMD_TRIGHT);

    assign res.command       = cmd;
    assign res.speed         = (is_torque || cmd == ltob_pkg::CMD_SPEED) ?
                               cfg.cruise_speed : 8'd0;
    assign res.torque        = is_torque ? cfg.torque_force : 8'd0;
    assign res.interruptible = intr;
    assign res.turn_rate     = (cmd == ltob_pkg::CMD_TURN) ? ltob_pkg::TURN_RATE_K : 8'd0;
    assign res.turn_time     = (cmd == ltob_pkg::CMD_TURN) ? ltob_pkg::TURN_TIME_K : 16'd0;
    assign res.mode          = mode_next;

endmodule

/* hw/rtl/line_trace_out_and_back_fsm_top.sv */
// A request waits in the input register, then its result is registered and raises out_valid.
// Throughput: one request per cycle; with out_ready low the input register takes one
// more request, then in_ready drops until the result register empties.
// Reset (rst_n, async, active low): mode returns to ready, both config registers
// clear to zero, and both pipeline stages empty.
module line_trace_out_and_back_fsm_top #(
    parameter int SPEED_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ltob_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ltob_pkg::out_t                 out_data,
    input  logic                           cfg_wr_en,
    input  logic [ltob_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);

    ltob_pkg::cfg_t cfg;
    ltob_pkg::out_t res;

    logic           s1_valid_reg;
    ltob_pkg::in_t  s1_data_reg;
    logic           out_valid_reg;
    ltob_pkg::out_t out_data_reg;
    logic [2:0]     mode_reg;
    logic [2:0]     mode_next;
    logic           advance;

    ltob_cfg_regs #(
        .SPEED_BITS (SPEED_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ltob_decide #(
        .SPEED_BITS (SPEED_BITS)
    ) u_decide (
        .mode (mode_reg),
        .req  (s1_data_reg),
        .cfg  (cfg),
        .res  (res)
    );

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign mode_next = advance ? res.mode : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= ltob_pkg::M_READY;
        end
        else
        begin
            mode_reg <= mode_next;
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hw/rtl/ltob_checker.sv */
module ltob_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_ready,
    input ltob_pkg::out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_turn_args: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.command == ltob_pkg::CMD_TURN |->
            out_data.turn_rate == ltob_pkg::TURN_RATE_K &&
            out_data.turn_time == ltob_pkg::TURN_TIME_K &&
            out_data.speed == 8'd0 && out_data.torque == 8'd0)
        else $error("turn arguments wrong");

    a_turn_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.command == ltob_pkg::CMD_TURN |->
            out_data.mode == ltob_pkg::M_SBACK)
        else $error("turn not followed by search back");

    a_torque_intr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.command == ltob_pkg::CMD_TLEFT ||
                      out_data.command == ltob_pkg::CMD_TRIGHT) |->
            out_data.interruptible && out_data.turn_time == 16'd0)
        else $error("torque command fields wrong");

endmodule

bind line_trace_out_and_back_fsm_top ltob_checker u_ltob_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
